// ===== hdl/texture_zoom_pixel_generator_macros.svh =====
// Assertion macros shared by the texture zoom checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef TEXTURE_ZOOM_PIXEL_GENERATOR_MACROS_SVH
`define TEXTURE_ZOOM_PIXEL_GENERATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define TZP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define TZP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tzp_pkg.sv =====
// Shared types, constants and helpers for the texture zoom pixel generator.
// No dependencies; used by the interfaces, tzp_coord, the top level and the checker.
package tzp_pkg;

	localparam int TEX_LOG2_MAX_DEF = 8;
	localparam int SCREEN_MAX_DEF   = 4096;

	localparam int FRAC_BITS  = 12;
	localparam int COORD_W    = 32;
	localparam int TEXEL_W    = 32;
	localparam int TEX_ADDR_W = 16;
	localparam int TEX_WORDS  = 65536;
	localparam int LOG2_W     = 4;
	localparam int SCR_W      = 13;
	localparam int POS_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int LOG2_RST   = 8;
	localparam int SCR_W_RST  = 640;
	localparam int SCR_H_RST  = 480;
	localparam int STEP_RST   = 4096;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_PIXEL = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_U_START  = 3'd0,
		REG_V_START  = 3'd1,
		REG_STEP_U   = 3'd2,
		REG_STEP_V   = 3'd3,
		REG_TEX_WL2  = 3'd4,
		REG_TEX_HL2  = 3'd5,
		REG_SCR_W    = 3'd6,
		REG_SCR_H    = 3'd7
	} cfg_reg_t;

	// screen position and line/frame marks of one pixel
	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic             eol;
		logic             eof;
	} pos_t;

	localparam logic [TEXEL_W-1:0] KEEP_AG = 32'hff00ff00;
	localparam logic [TEXEL_W-1:0] BYTE_2  = 32'h00ff0000;
	localparam logic [TEXEL_W-1:0] BYTE_0  = 32'h000000ff;

	function automatic logic [TEXEL_W-1:0] abgr_to_argb(input logic [TEXEL_W-1:0] t);
		return (t & KEEP_AG) | ((t & BYTE_2) >> 16) | ((t & BYTE_0) << 16);
	endfunction

endpackage

// ===== hdl/tzp_in_if.sv =====
// Request channel: texel load or pixel request beats.
// Depends on tzp_pkg for field widths.
interface tzp_in_if;
	logic                             valid;
	logic                             ready;
	logic                             action;
	logic [tzp_pkg::TEX_ADDR_W-1:0]   texel_index;
	logic [tzp_pkg::TEXEL_W-1:0]      texel_value;

	modport source (output valid, output action, output texel_index, output texel_value,
		input ready);
	modport sink (input valid, input action, input texel_index, input texel_value,
		output ready);
endinterface

// ===== hdl/tzp_out_if.sv =====
// Result channel: one beat per generated screen pixel.
// Depends on tzp_pkg for field widths.
interface tzp_out_if;
	logic                        valid;
	logic                        ready;
	logic [tzp_pkg::TEXEL_W-1:0] pixel;
	logic [tzp_pkg::POS_W-1:0]   pixel_x;
	logic [tzp_pkg::POS_W-1:0]   pixel_y;
	logic                        end_of_line;
	logic                        end_of_frame;

	modport source (output valid, output pixel, output pixel_x, output pixel_y,
		output end_of_line, output end_of_frame, input ready);
	modport sink (input valid, input pixel, input pixel_x, input pixel_y,
		input end_of_line, input end_of_frame, output ready);
endinterface

// ===== hdl/tzp_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module tzp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/tzp_coord.sv =====
// Configuration registers, raster counters and Q.12 texture coordinate accumulators.
// Depends on tzp_pkg; produces the texel address and position of the next pixel.
module tzp_coord #(
	parameter int TEX_LOG2_MAX = tzp_pkg::TEX_LOG2_MAX_DEF,
	parameter int SCREEN_MAX   = tzp_pkg::SCREEN_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tzp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tzp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            advance,
	output logic [tzp_pkg::TEX_ADDR_W-1:0]  tex_addr,
	output tzp_pkg::pos_t                   pos
);

	localparam int CNT_W   = $clog2(SCREEN_MAX);
	localparam int CMP_W   = tzp_pkg::SCR_W + 1;
	localparam int INT_W   = tzp_pkg::COORD_W - tzp_pkg::FRAC_BITS;
	localparam int LOG2_W  = tzp_pkg::LOG2_W;
	localparam int SCR_W   = tzp_pkg::SCR_W;
	localparam int COORD_W = tzp_pkg::COORD_W;

	localparam logic [LOG2_W-1:0] LOG2_CAP = LOG2_W'(TEX_LOG2_MAX);
	localparam logic [LOG2_W-1:0] LOG2_RST = LOG2_W'((tzp_pkg::LOG2_RST > TEX_LOG2_MAX) ?
		TEX_LOG2_MAX : tzp_pkg::LOG2_RST);
	localparam logic [SCR_W-1:0]  SCR_CAP  = SCR_W'(SCREEN_MAX);
	localparam logic [SCR_W-1:0]  SW_RST   = SCR_W'((tzp_pkg::SCR_W_RST > SCREEN_MAX) ?
		SCREEN_MAX : tzp_pkg::SCR_W_RST);
	localparam logic [SCR_W-1:0]  SH_RST   = SCR_W'((tzp_pkg::SCR_H_RST > SCREEN_MAX) ?
		SCREEN_MAX : tzp_pkg::SCR_H_RST);

	function automatic logic [LOG2_W-1:0] clamp_log2(input logic [LOG2_W-1:0] v);
		return (int'(v) > TEX_LOG2_MAX) ? LOG2_CAP : v;
	endfunction

	function automatic logic [SCR_W-1:0] clamp_scr(input logic [SCR_W-1:0] v);
		logic [SCR_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SCR_W'(1);
		end else if (int'(v) > SCREEN_MAX) begin
			r = SCR_CAP;
		end
		return r;
	endfunction

	// configuration, sizes stored already clamped
	logic [COORD_W-1:0] u_start_q, v_start_q, step_u_q, step_v_q;
	logic [LOG2_W-1:0]  wl_q, hl_q;
	logic [SCR_W-1:0]   sw_q, sh_q;

	// raster state
	logic [COORD_W-1:0] u_q, v_q;
	logic [CNT_W-1:0]   col_q, row_q;

	logic [COORD_W-1:0] u_cur, v_cur;
	logic [INT_W-1:0]   ui, vi, wmask, hmask;
	logic [COORD_W-1:0] addr_full;
	logic [CMP_W-1:0]   col_inc, row_inc;
	logic               eol, eof;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_start_q <= '0;
			v_start_q <= '0;
			step_u_q  <= COORD_W'(tzp_pkg::STEP_RST);
			step_v_q  <= COORD_W'(tzp_pkg::STEP_RST);
			wl_q      <= LOG2_RST;
			hl_q      <= LOG2_RST;
			sw_q      <= SW_RST;
			sh_q      <= SH_RST;
		end else if (cfg_we) begin
			case (tzp_pkg::cfg_reg_t'(cfg_index))
				tzp_pkg::REG_U_START: u_start_q <= cfg_data;
				tzp_pkg::REG_V_START: v_start_q <= cfg_data;
				tzp_pkg::REG_STEP_U:  step_u_q  <= cfg_data;
				tzp_pkg::REG_STEP_V:  step_v_q  <= cfg_data;
				tzp_pkg::REG_TEX_WL2: wl_q      <= clamp_log2(cfg_data[LOG2_W-1:0]);
				tzp_pkg::REG_TEX_HL2: hl_q      <= clamp_log2(cfg_data[LOG2_W-1:0]);
				tzp_pkg::REG_SCR_W:   sw_q      <= clamp_scr(cfg_data[SCR_W-1:0]);
				tzp_pkg::REG_SCR_H:   sh_q      <= clamp_scr(cfg_data[SCR_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		u_cur     = (col_q == '0) ? u_start_q : u_q;
		v_cur     = (col_q == '0 && row_q == '0) ? v_start_q : v_q;
		wmask     = (INT_W'(1) << wl_q) - INT_W'(1);
		hmask     = (INT_W'(1) << hl_q) - INT_W'(1);
		ui        = u_cur[COORD_W-1:tzp_pkg::FRAC_BITS] & wmask;
		vi        = v_cur[COORD_W-1:tzp_pkg::FRAC_BITS] & hmask;
		addr_full = (COORD_W'(vi) << wl_q) | COORD_W'(ui);
		col_inc   = CMP_W'(col_q) + CMP_W'(1);
		row_inc   = CMP_W'(row_q) + CMP_W'(1);
		// a counter past a shrunk size ends its line or frame
		eol       = col_inc >= CMP_W'(sw_q);
		eof       = eol && (row_inc >= CMP_W'(sh_q));
	end

	assign tex_addr = addr_full[tzp_pkg::TEX_ADDR_W-1:0];
	assign pos.x    = tzp_pkg::POS_W'(col_q);
	assign pos.y    = tzp_pkg::POS_W'(row_q);
	assign pos.eol  = eol;
	assign pos.eof  = eof;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_q   <= '0;
			v_q   <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (eof) begin
				col_q <= '0;
				row_q <= '0;
				u_q   <= u_start_q;
				v_q   <= v_start_q;
			end else if (eol) begin
				col_q <= '0;
				row_q <= CNT_W'(row_inc);
				u_q   <= u_start_q;
				v_q   <= v_cur + step_v_q;
			end else begin
				col_q <= CNT_W'(col_inc);
				u_q   <= u_cur + step_u_q;
				v_q   <= v_cur;
			end
		end
	end

endmodule

// ===== hdl/texture_zoom_pixel_generator.sv =====
// Nearest-neighbor zoom of a wrapping power-of-two texture held in a 64K x 32 texture RAM.
// A load beat (action 0) stores one ABGR texel and gives no result; a pixel beat (action 1)
// gives the next screen pixel in raster order as ARGB with its x, y and end-of-line and
// end-of-frame marks. One beat is taken every clock while the result side keeps up. A pixel
// request is read into the registered texture RAM output as it is taken and moves on into the
// result register once that register is free. The RAM read stage and the result register hold
// one pixel each, so one more request is taken while a result waits; with both full the input
// stalls until the result is taken. Texture RAM contents are undefined until loaded; there is
// no clearing pass. Configuration must be written through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block itself does not enforce this. Depends on tzp_pkg, tzp_in_if,
// tzp_out_if, tzp_ram and tzp_coord.
module texture_zoom_pixel_generator #(
	parameter int TEX_LOG2_MAX = tzp_pkg::TEX_LOG2_MAX_DEF,
	parameter int SCREEN_MAX   = tzp_pkg::SCREEN_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tzp_in_if.sink                         request,
	tzp_out_if.source                      result,
	input  logic                           cfg_we,
	input  logic [tzp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tzp_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                            accept;
	logic                            is_pixel;
	logic                            out_free;
	logic [tzp_pkg::TEX_ADDR_W-1:0]  rd_addr;
	logic [tzp_pkg::TEX_ADDR_W-1:0]  ram_addr;
	logic [tzp_pkg::TEXEL_W-1:0]     rdata;
	tzp_pkg::pos_t                   pos_next;

	// stage 1: texture read in flight
	logic                            valid_s1;
	tzp_pkg::pos_t                   pos_s1;

	// stage 2: result register
	logic                            valid_s2;
	logic [tzp_pkg::TEXEL_W-1:0]     pixel_s2;
	tzp_pkg::pos_t                   pos_s2;

	// result register frees when empty or taken; stage 1 then moves up
	assign out_free      = !valid_s2 || result.ready;
	assign request.ready = !valid_s1 || out_free;
	assign accept        = request.valid && request.ready;
	assign is_pixel      = (request.action == tzp_pkg::ACT_PIXEL);

	tzp_coord #(
		.TEX_LOG2_MAX (TEX_LOG2_MAX),
		.SCREEN_MAX   (SCREEN_MAX)
	) u_coord (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept && is_pixel),
		.tex_addr  (rd_addr),
		.pos       (pos_next)
	);

	// one port: a load beat writes, a pixel beat reads
	assign ram_addr = is_pixel ? rd_addr : request.texel_index;

	tzp_ram #(
		.WIDTH (tzp_pkg::TEXEL_W),
		.DEPTH (tzp_pkg::TEX_WORDS)
	) u_tex_ram (
		.clk   (clk),
		.we    (accept && !is_pixel),
		.re    (accept && is_pixel),
		.addr  (ram_addr),
		.wdata (request.texel_value),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && is_pixel) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_pixel) begin
			pos_s1 <= pos_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			pixel_s2 <= tzp_pkg::abgr_to_argb(rdata);
			pos_s2   <= pos_s1;
		end
	end

	assign result.valid        = valid_s2;
	assign result.pixel        = pixel_s2;
	assign result.pixel_x      = pos_s2.x;
	assign result.pixel_y      = pos_s2.y;
	assign result.end_of_line  = pos_s2.eol;
	assign result.end_of_frame = pos_s2.eof;

endmodule

// ===== hdl/tzp_checker.sv =====
// Port-level checker for the texture zoom pixel generator, bound to the top level.
// Depends on tzp_pkg and texture_zoom_pixel_generator_macros.svh.
`include "texture_zoom_pixel_generator_macros.svh"

module tzp_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [tzp_pkg::POS_W-1:0]   pixel_x,
	input  logic [tzp_pkg::POS_W-1:0]   pixel_y,
	input  logic                        eol,
	input  logic                        eof
);

	logic                      out_beat;
	logic [tzp_pkg::POS_W-1:0] x_exp_q;
	logic [tzp_pkg::POS_W-1:0] y_exp_q;

	assign out_beat = out_valid && out_ready;

	// expected raster position of the next result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_exp_q <= '0;
			y_exp_q <= '0;
		end else if (out_beat) begin
			if (eof) begin
				x_exp_q <= '0;
				y_exp_q <= '0;
			end else if (eol) begin
				x_exp_q <= '0;
				y_exp_q <= pixel_y + tzp_pkg::POS_W'(1);
			end else begin
				x_exp_q <= pixel_x + tzp_pkg::POS_W'(1);
			end
		end
	end

	`TZP_ASSERT_NXT(a_valid_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`TZP_ASSERT_IMP(a_eof_eol, clk, arst_n, out_valid, !eof || eol, "end of frame without end of line")
	`TZP_ASSERT_IMP(a_x_order, clk, arst_n, out_valid, pixel_x == x_exp_q, "pixel column out of raster order")
	`TZP_ASSERT_IMP(a_y_order, clk, arst_n, out_valid, pixel_y == y_exp_q, "pixel line out of raster order")

endmodule

bind texture_zoom_pixel_generator tzp_checker u_tzp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.pixel_x   (result.pixel_x),
	.pixel_y   (result.pixel_y),
	.eol       (result.end_of_line),
	.eof       (result.end_of_frame)
);
